>>> design/cpc_pkg.sv
// shared constants, types and the arctangent table for the cartesian to polar block
// no dependencies

package cpc_pkg;

  localparam int COORD_W       = 16;
  localparam int CORDIC_STAGES = 16;
  localparam int ROOT_STEPS    = COORD_W;
  localparam int NUM_CELLS     = (CORDIC_STAGES > ROOT_STEPS) ? CORDIC_STAGES : ROOT_STEPS;
  localparam int CELL_IDX_W    = $clog2(NUM_CELLS);

  localparam int MAG_W     = COORD_W + 1;
  localparam int SUM_W     = 2 * COORD_W;
  localparam int PRE_SHIFT = 47 - COORD_W;
  localparam int CW        = PRE_SHIFT + MAG_W + 2;
  localparam int Z_W       = 25;

  localparam int DIST_W = 16;
  localparam int HEAD_W = 12;
  localparam int DIR_W  = 4;

  localparam int ANG_FRAC   = 16;
  localparam int H_W        = 28;
  localparam int PROD_W     = H_W + 3;
  localparam int TEN_W      = 14;
  localparam int HEAD_MOD   = 3600;

  localparam logic signed [H_W-1:0] ANG_180 = H_W'(180 * (1 << ANG_FRAC));
  localparam logic signed [H_W-1:0] ANG_360 = H_W'(360 * (1 << ANG_FRAC));
  localparam logic [PROD_W-1:0] ROUND_HALF  = PROD_W'(1 << (ANG_FRAC - 1));
  localparam logic [TEN_W-1:0]  TURN_ONE    = TEN_W'(HEAD_MOD);
  localparam logic [TEN_W-1:0]  TURN_TWO    = TEN_W'(2 * HEAD_MOD);
  localparam logic [DIST_W-1:0] DIST_MAX    = '1;

  localparam logic [DIR_W-1:0] DIR_CENTRE = 4'd0;
  localparam logic [DIR_W-1:0] DIR_N      = 4'd1;
  localparam logic [DIR_W-1:0] DIR_S      = 4'd2;
  localparam logic [DIR_W-1:0] DIR_E      = 4'd3;
  localparam logic [DIR_W-1:0] DIR_W_     = 4'd4;
  localparam logic [DIR_W-1:0] DIR_NE     = 4'd5;
  localparam logic [DIR_W-1:0] DIR_SE     = 4'd6;
  localparam logic [DIR_W-1:0] DIR_NW     = 4'd7;
  localparam logic [DIR_W-1:0] DIR_SW     = 4'd8;

  typedef struct packed {
    logic signed [CW-1:0]  cx;
    logic signed [CW-1:0]  cy;
    logic signed [Z_W-1:0] z;
    logic [SUM_W-1:0]      rem;
    logic [SUM_W-1:0]      root;
    logic [DIR_W-1:0]      dir;
    logic                  xneg;
    logic                  yneg;
    logic                  quad;
  } cell_t;

  typedef struct packed {
    logic [DIST_W-1:0] distance;
    logic [HEAD_W-1:0] heading;
    logic [DIR_W-1:0]  direction;
    logic              angle_valid;
  } res_t;

  // atan(2^-i) in units of 2^-16 degree
  function automatic logic signed [Z_W-1:0] atan_val(input logic [4:0] i);
    logic signed [Z_W-1:0] v;
    case (i)
      5'd0:    v = Z_W'(2949120);
      5'd1:    v = Z_W'(1740967);
      5'd2:    v = Z_W'(919879);
      5'd3:    v = Z_W'(466945);
      5'd4:    v = Z_W'(234379);
      5'd5:    v = Z_W'(117304);
      5'd6:    v = Z_W'(58666);
      5'd7:    v = Z_W'(29335);
      5'd8:    v = Z_W'(14668);
      5'd9:    v = Z_W'(7334);
      5'd10:   v = Z_W'(3667);
      5'd11:   v = Z_W'(1833);
      5'd12:   v = Z_W'(917);
      5'd13:   v = Z_W'(458);
      5'd14:   v = Z_W'(229);
      5'd15:   v = Z_W'(115);
      5'd16:   v = Z_W'(57);
      5'd17:   v = Z_W'(29);
      5'd18:   v = Z_W'(14);
      5'd19:   v = Z_W'(7);
      5'd20:   v = Z_W'(4);
      5'd21:   v = Z_W'(2);
      5'd22:   v = Z_W'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

>>> design/cpc_if.sv
// valid/ready channels for point beats in and polar beats out
// depends on cpc_pkg

interface cpc_in_if import cpc_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic signed [COORD_W-1:0] x_coord;
  logic signed [COORD_W-1:0] y_coord;

  modport source (output valid, output x_coord, output y_coord, input ready);
  modport sink   (input valid, input x_coord, input y_coord, output ready);
endinterface

interface cpc_out_if import cpc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [DIST_W-1:0] distance;
  logic [HEAD_W-1:0] heading;
  logic [DIR_W-1:0]  direction;
  logic              angle_valid;

  modport source (output valid, output distance, output heading, output direction,
                  output angle_valid, input ready);
  modport sink   (input valid, input distance, input heading, input direction,
                  input angle_valid, output ready);
endinterface

>>> design/cpc_cell.sv
// one cell of the chain: one cordic vectoring step and one square root digit
// depends on cpc_pkg

module cpc_cell import cpc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  en,
  input  logic [CELL_IDX_W-1:0] idx,
  input  logic                  in_valid,
  input  cell_t                 in_data,
  output logic                  out_valid,
  output cell_t                 out_data
);

  logic signed [CW-1:0]  cx, cy, dx, dy;
  logic signed [Z_W-1:0] z, ang;
  logic [SUM_W-1:0]      root_bit, trial;
  cell_t                 nxt;

  assign cx  = in_data.cx;
  assign cy  = in_data.cy;
  assign z   = in_data.z;
  assign dx  = cy >>> idx;
  assign dy  = cx >>> idx;
  assign ang = atan_val(5'(idx));

  assign root_bit = (idx < ROOT_STEPS)
                  ? (SUM_W'(1) << (2 * (ROOT_STEPS - 1 - 32'(idx)))) : '0;
  assign trial    = in_data.root + root_bit;

  always_comb begin
    nxt = in_data;
    if (idx < CORDIC_STAGES) begin
      if (!cy[CW-1]) begin
        nxt.cx = cx + dx;
        nxt.cy = cy - dy;
        nxt.z  = z + ang;
      end else begin
        nxt.cx = cx - dx;
        nxt.cy = cy + dy;
        nxt.z  = z - ang;
      end
    end
    if (idx < ROOT_STEPS) begin
      if (in_data.rem >= trial) begin
        nxt.rem  = in_data.rem - trial;
        nxt.root = (in_data.root >> 1) + root_bit;
      end else begin
        nxt.root = in_data.root >> 1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_data <= nxt;
    end
  end

endmodule

>>> design/cpc_finish.sv
// final two stages: distance rounding, quadrant fold, tenths rounding and wrap
// depends on cpc_pkg

module cpc_finish import cpc_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  en,
  input  logic  in_valid,
  input  cell_t in_data,
  output logic  out_valid,
  output res_t  out_data
);

  logic                  f1_valid;
  logic [DIST_W-1:0]     f1_dist;
  logic [TEN_W-1:0]      f1_tenths;
  logic [DIR_W-1:0]      f1_dir;
  logic                  f1_quad;

  logic signed [H_W-1:0] t, h_base, h_sum;
  logic [H_W-1:0]        h_pos;
  logic [PROD_W-1:0]     prod;
  logic [SUM_W:0]        root_up;
  logic [DIST_W-1:0]     dist_next;
  logic [TEN_W-1:0]      wrapped;

  assign t = H_W'(in_data.z);

  always_comb begin
    case ({in_data.xneg, in_data.yneg})
      2'b00:   h_base = t;
      2'b01:   h_base = ANG_360 - t;
      2'b10:   h_base = ANG_180 - t;
      default: h_base = ANG_180 + t;
    endcase
    h_sum = h_base + ANG_360;
    h_pos = h_sum[H_W-1] ? '0 : h_sum;
    prod  = (PROD_W'(h_pos) << 3) + (PROD_W'(h_pos) << 1) + ROUND_HALF;
  end

  always_comb begin
    root_up = (SUM_W+1)'(in_data.root) + (SUM_W+1)'(in_data.rem > in_data.root);
    if (root_up > (SUM_W+1)'(DIST_MAX)) begin
      dist_next = DIST_MAX;
    end else begin
      dist_next = root_up[DIST_W-1:0];
    end
  end

  always_comb begin
    if (f1_tenths >= TURN_TWO) begin
      wrapped = f1_tenths - TURN_TWO;
    end else if (f1_tenths >= TURN_ONE) begin
      wrapped = f1_tenths - TURN_ONE;
    end else begin
      wrapped = f1_tenths;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else if (en) begin
      f1_valid  <= in_valid;
      out_valid <= f1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f1_dist   <= dist_next;
      f1_tenths <= prod[ANG_FRAC +: TEN_W];
      f1_dir    <= in_data.dir;
      f1_quad   <= in_data.quad;
      out_data.distance    <= f1_dist;
      out_data.heading     <= f1_quad ? wrapped[HEAD_W-1:0] : '0;
      out_data.direction   <= f1_dir;
      out_data.angle_valid <= f1_quad;
    end
  end

endmodule

>>> design/cpc_skid.sv
// two-entry output buffer that decouples the pipeline from the result channel
// depends on cpc_pkg and cpc_out_if

module cpc_skid import cpc_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  res_t             push_data,
  output logic             room,
  cpc_out_if.source        polar
);

  res_t       slot [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       pop;
  res_t       head;

  assign pop  = polar.valid && polar.ready;
  assign room = (count != 2'd2);
  assign head = slot[rd_ptr];

  assign polar.valid       = (count != 2'd0);
  assign polar.distance    = head.distance;
  assign polar.heading     = head.heading;
  assign polar.direction   = head.direction;
  assign polar.angle_valid = head.angle_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop) begin
        rd_ptr <= ~rd_ptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot[wr_ptr] <= push_data;
    end
  end

endmodule

>>> design/cartesian_to_polar_compass.sv
// cartesian to polar conversion with nine-way compass class
// depends on cpc_pkg, cpc_if, cpc_cell, cpc_finish, cpc_skid
// pipeline: squaring stage, sum stage, 16 cells, two finishing stages, output buffer
// throughput: one beat per cycle while the output buffer has room
// a two-entry output buffer keeps the input ready while at most one result waits
// reset clears all valid bits and buffer pointers, data registers are not reset

module cartesian_to_polar_compass import cpc_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  cpc_in_if.sink    point,
  cpc_out_if.source polar
);

  logic                      en;
  logic signed [COORD_W-1:0] x, y;
  logic signed [MAG_W-1:0]   x_ext, y_ext;
  logic [MAG_W-1:0]          ax, ay;
  logic signed [SUM_W-1:0]   xsq_full, ysq_full;
  logic [DIR_W-1:0]          dir_next;

  logic                      a_valid;
  logic [SUM_W-1:0]          a_xsq, a_ysq;
  logic [MAG_W-1:0]          a_ax, a_ay;
  logic [DIR_W-1:0]          a_dir;
  logic                      a_xneg, a_yneg, a_quad;

  cell_t                     b_init;
  logic                      chain_valid [NUM_CELLS+1];
  cell_t                     chain       [NUM_CELLS+1];

  logic                      fin_valid;
  res_t                      fin_data;

  assign x        = point.x_coord;
  assign y        = point.y_coord;
  assign x_ext    = MAG_W'(x);
  assign y_ext    = MAG_W'(y);
  assign ax       = x[COORD_W-1] ? MAG_W'(-x_ext) : MAG_W'(x_ext);
  assign ay       = y[COORD_W-1] ? MAG_W'(-y_ext) : MAG_W'(y_ext);
  assign xsq_full = x * x;
  assign ysq_full = y * y;

  assign point.ready = en;

  always_comb begin
    if (x == '0 && y == '0) begin
      dir_next = DIR_CENTRE;
    end else if (x == '0) begin
      dir_next = y[COORD_W-1] ? DIR_S : DIR_N;
    end else if (y == '0) begin
      dir_next = x[COORD_W-1] ? DIR_W_ : DIR_E;
    end else begin
      case ({x[COORD_W-1], y[COORD_W-1]})
        2'b00:   dir_next = DIR_NE;
        2'b01:   dir_next = DIR_SE;
        2'b10:   dir_next = DIR_NW;
        default: dir_next = DIR_SW;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid        <= 1'b0;
      chain_valid[0] <= 1'b0;
    end else if (en) begin
      a_valid        <= point.valid;
      chain_valid[0] <= a_valid;
    end
  end

  always_comb begin
    b_init      = '0;
    b_init.cx   = CW'(a_ax) << PRE_SHIFT;
    b_init.cy   = CW'(a_ay) << PRE_SHIFT;
    b_init.rem  = a_xsq + a_ysq;
    b_init.dir  = a_dir;
    b_init.xneg = a_xneg;
    b_init.yneg = a_yneg;
    b_init.quad = a_quad;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_xsq    <= SUM_W'(xsq_full);
      a_ysq    <= SUM_W'(ysq_full);
      a_ax     <= ax;
      a_ay     <= ay;
      a_dir    <= dir_next;
      a_xneg   <= x[COORD_W-1];
      a_yneg   <= y[COORD_W-1];
      a_quad   <= (x != '0) && (y != '0);
      chain[0] <= b_init;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    cpc_cell u_cell (
      .clk       (clk),
      .rst       (rst),
      .en        (en),
      .idx       (CELL_IDX_W'(k)),
      .in_valid  (chain_valid[k]),
      .in_data   (chain[k]),
      .out_valid (chain_valid[k+1]),
      .out_data  (chain[k+1])
    );
  end

  cpc_finish u_finish (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (chain_valid[NUM_CELLS]),
    .in_data   (chain[NUM_CELLS]),
    .out_valid (fin_valid),
    .out_data  (fin_data)
  );

  cpc_skid u_skid (
    .clk       (clk),
    .rst       (rst),
    .push      (fin_valid && en),
    .push_data (fin_data),
    .room      (en),
    .polar     (polar)
  );

  a_accept_enters: assert property (@(posedge clk) disable iff (rst)
    (point.valid && point.ready) |=> a_valid)
    else $error("accepted beat did not enter the pipeline");

  a_angle_quadrant: assert property (@(posedge clk) disable iff (rst)
    (polar.valid && polar.angle_valid) |-> (polar.direction >= DIR_NE))
    else $error("angle flagged for a point outside the quadrants");

  a_heading_range: assert property (@(posedge clk) disable iff (rst)
    polar.valid |-> (polar.heading < HEAD_W'(HEAD_MOD)))
    else $error("heading beyond a full turn");

  a_heading_zero: assert property (@(posedge clk) disable iff (rst)
    (polar.valid && !polar.angle_valid) |-> (polar.heading == '0))
    else $error("heading nonzero without a valid angle");

endmodule

>>> bench/tb_top.sv
`timescale 1ns / 100ps
// testbench for cartesian_to_polar_compass: directed table then random points, scored by
// fixed expected values or an in-bench predictor of distance, heading and compass class
// depends on cpc_pkg, cpc_if and the design files

module tb_top import cpc_pkg::*; ();

  localparam int     CYCLE_LIMIT = 200000;
  localparam int     RANDOM_ITEMS = 450;
  localparam int     SETTLE_CYCLES = 40;
  localparam int     NUM_STAGES = 16;
  localparam int     LIFT = 31;
  localparam longint ONE_DEG = 64'sd65536;

  typedef struct {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    bit                        fixed;
    res_t                      want;
  } stim_row_t;

  typedef struct {
    bit   fixed;
    res_t want;
  } tag_t;

  logic clk = 1'b0;
  logic rst;

  cpc_in_if  point ();
  cpc_out_if polar ();

  cartesian_to_polar_compass dut (
    .clk,
    .rst,
    .point,
    .polar
  );

  longint    atan_step [0:NUM_STAGES-1] = '{
    2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
    14668, 7334, 3667, 1833, 917, 458, 229, 115
  };
  stim_row_t stim_table [$];
  tag_t      tag_q [$];
  res_t      polar_pending [$];
  int        errors = 0;
  int        cycles = 0;
  bit        calm = 1'b0;

  always #5 clk = ~clk;

  // distance, compass class and heading of one point
  function automatic res_t polar_of(input logic signed [COORD_W-1:0] x,
                                    input logic signed [COORD_W-1:0] y);
    longint sx, sy, ax, ay, sq, rem, root, bitv, cx, cy, z, dx, dy, h, tenths;
    int     i;
    res_t   r;
    sx = x;
    sy = y;
    ax = (sx < 0) ? -sx : sx;
    ay = (sy < 0) ? -sy : sy;
    sq = ax * ax + ay * ay;
    rem = sq;
    root = 0;
    bitv = 64'sd1 << 62;
    while (bitv > rem) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem = rem - (root + bitv);
        root = (root >> 1) + bitv;
      end else begin
        root = root >> 1;
      end
      bitv = bitv >> 2;
    end
    if (sq - root * root > root) root++;
    if (root > 65535) root = 65535;
    r.distance = DIST_W'(root);
    r.heading = '0;
    r.angle_valid = 1'b0;
    if (sx == 0 && sy == 0) begin
      r.direction = DIR_CENTRE;
    end else if (sx == 0) begin
      r.direction = (sy > 0) ? DIR_N : DIR_S;
    end else if (sy == 0) begin
      r.direction = (sx > 0) ? DIR_E : DIR_W_;
    end else begin
      cx = ax << LIFT;
      cy = ay << LIFT;
      z = 0;
      for (i = 0; i < NUM_STAGES; i++) begin
        dx = cy >>> i;
        dy = cx >>> i;
        if (cy >= 0) begin
          cx = cx + dx;
          cy = cy - dy;
          z = z + atan_step[i];
        end else begin
          cx = cx - dx;
          cy = cy + dy;
          z = z - atan_step[i];
        end
      end
      if (sx > 0 && sy > 0) begin
        r.direction = DIR_NE;
        h = z;
      end else if (sx > 0) begin
        r.direction = DIR_SE;
        h = 360 * ONE_DEG - z;
      end else if (sy > 0) begin
        r.direction = DIR_NW;
        h = 180 * ONE_DEG - z;
      end else begin
        r.direction = DIR_SW;
        h = 180 * ONE_DEG + z;
      end
      h = h + 360 * ONE_DEG;
      if (h < 0) h = 0;
      tenths = (h * 10 + 32768) >>> 16;
      r.heading = HEAD_W'(tenths % 3600);
      r.angle_valid = 1'b1;
    end
    return r;
  endfunction

  task automatic note_fault(input string msg);
    errors++;
    if (errors <= 10) $display("%s", msg);
  endtask

  task automatic add_row(input int x, input int y, input bit fixed, input int len,
                         input int head, input logic [DIR_W-1:0] dir, input bit ok);
    stim_row_t row;
    row.x = COORD_W'(x);
    row.y = COORD_W'(y);
    row.fixed = fixed;
    row.want.distance = DIST_W'(len);
    row.want.heading = HEAD_W'(head);
    row.want.direction = dir;
    row.want.angle_valid = ok;
    stim_table.push_back(row);
  endtask

  // called at a falling edge, returns at the falling edge after the beat is taken
  task automatic send_point(input logic signed [COORD_W-1:0] x,
                            input logic signed [COORD_W-1:0] y,
                            input bit fixed, input res_t want);
    tag_t tag;
    while (!calm && $urandom_range(0, 99) < 24) begin
      point.valid <= 1'b0;
      @(negedge clk);
    end
    tag.fixed = fixed;
    tag.want = want;
    tag_q.push_back(tag);
    point.valid <= 1'b1;
    point.x_coord <= x;
    point.y_coord <= y;
    @(posedge clk);
    while (!point.ready) @(posedge clk);
    @(negedge clk);
  endtask

  // result side back-pressure
  always @(negedge clk) begin
    polar.ready <= calm ? 1'b1 : ($urandom_range(0, 99) >= 24);
  end

  always @(posedge clk) begin
    tag_t tag;
    res_t want;
    if (!rst) begin
      if (point.valid && point.ready) begin
        tag = tag_q.pop_front();
        if (tag.fixed) polar_pending.push_back(tag.want);
        else polar_pending.push_back(polar_of(point.x_coord, point.y_coord));
      end
      if (polar.valid && polar.ready) begin
        if (polar_pending.size() == 0) begin
          note_fault($sformatf("unexpected beat: dist %0d head %0d dir %0d ok %0b",
                               polar.distance, polar.heading, polar.direction,
                               polar.angle_valid));
        end else begin
          want = polar_pending.pop_front();
          if (polar.distance !== want.distance || polar.heading !== want.heading ||
              polar.direction !== want.direction ||
              polar.angle_valid !== want.angle_valid) begin
            note_fault($sformatf(
              "mismatch: exp dist %0d head %0d dir %0d ok %0b, got %0d %0d %0d %0b",
              want.distance, want.heading, want.direction, want.angle_valid,
              polar.distance, polar.heading, polar.direction, polar.angle_valid));
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("tb_top: errors");
      $finish;
    end
  end

  initial begin
    logic signed [COORD_W-1:0] corner_vals [0:4];
    logic signed [COORD_W-1:0] x, y;
    int   kind, m, n;
    res_t none;
    corner_vals[0] = -16'sd32768;
    corner_vals[1] = -16'sd1;
    corner_vals[2] = 16'sd0;
    corner_vals[3] = 16'sd1;
    corner_vals[4] = 16'sd32767;
    none = '0;
    rst = 1'b1;
    point.valid = 1'b0;
    point.x_coord = '0;
    point.y_coord = '0;
    polar.ready = 1'b0;

    add_row(0, 0, 1, 0, 0, DIR_CENTRE, 0);
    add_row(256, 0, 1, 256, 0, DIR_E, 0);
    add_row(0, 256, 1, 256, 0, DIR_N, 0);
    add_row(-256, 0, 1, 256, 0, DIR_W_, 0);
    add_row(0, -256, 1, 256, 0, DIR_S, 0);
    add_row(32767, 0, 1, 32767, 0, DIR_E, 0);
    add_row(-32768, 0, 1, 32768, 0, DIR_W_, 0);
    add_row(0, 32767, 1, 32767, 0, DIR_N, 0);
    add_row(0, -32768, 1, 32768, 0, DIR_S, 0);
    add_row(-32768, -32768, 1, 46341, 2250, DIR_SW, 1);
    add_row(1, 0, 1, 1, 0, DIR_E, 0);
    add_row(0, -1, 1, 1, 0, DIR_S, 0);
    add_row(1, 1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(1, -1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(-1, 1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(-1, -1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(32767, 32767, 0, 0, 0, DIR_CENTRE, 0);
    add_row(32767, -32768, 0, 0, 0, DIR_CENTRE, 0);
    add_row(-32768, 32767, 0, 0, 0, DIR_CENTRE, 0);
    add_row(32767, 1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(32767, -1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(1, 32767, 0, 0, 0, DIR_CENTRE, 0);
    add_row(-32768, -1, 0, 0, 0, DIR_CENTRE, 0);
    add_row(768, 1024, 0, 0, 0, DIR_CENTRE, 0);

    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (stim_table[i])
      send_point(stim_table[i].x, stim_table[i].y, stim_table[i].fixed, stim_table[i].want);

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      calm = (i >= 150 && i < 250);
      kind = $urandom_range(0, 9);
      if (kind <= 4) begin
        x = COORD_W'($urandom);
        y = COORD_W'($urandom);
      end else if (kind == 5) begin
        x = COORD_W'($urandom_range(0, 8) - 4);
        y = COORD_W'($urandom_range(0, 8) - 4);
      end else if (kind == 6) begin
        m = $urandom_range(0, 1);
        x = m ? COORD_W'($urandom) : '0;
        y = m ? '0 : COORD_W'($urandom);
      end else if (kind == 7) begin
        n = $urandom_range(0, 32768);
        x = COORD_W'($urandom_range(0, 1) ? n : -n);
        y = COORD_W'($urandom_range(0, 1) ? n : -n);
      end else if (kind == 8) begin
        x = corner_vals[$urandom_range(0, 4)];
        y = corner_vals[$urandom_range(0, 4)];
      end else begin
        x = COORD_W'($urandom_range(0, 4096) - 2048);
        y = COORD_W'($urandom_range(0, 4096) - 2048);
      end
      send_point(x, y, 1'b0, none);
    end
    calm = 1'b0;
    point.valid <= 1'b0;

    while (polar_pending.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (errors == 0) begin
      $display("tb_top: clean");
    end else begin
      $display("tb_top: errors");
    end
    $finish;
  end

endmodule

>>> cartesian_to_polar_compass.f
design/cpc_pkg.sv
design/cpc_if.sv
design/cpc_cell.sv
design/cpc_finish.sv
design/cpc_skid.sv
design/cartesian_to_polar_compass.sv
bench/tb_top.sv
